[src/lcp_pkg.sv]
package lcp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT   = 3'd0,
        REG_BOTTOM = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_TOP    = 3'd3
    } cfg_reg_t;

    // per-beat control carried alongside the data
    typedef struct packed {
        logic valid;
        logic reject;
    } lcp_ctrl_t;

endpackage

[src/lcp_setup.sv]
module lcp_setup #(
    parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] window_left,
    input  logic signed [COORD_BITS-1:0] window_bottom,
    input  logic signed [COORD_BITS-1:0] window_right,
    input  logic signed [COORD_BITS-1:0] window_top,
    output lcp_pkg::lcp_ctrl_t           ctrl,
    output logic [COORD_BITS-1:0]        sx,
    output logic [COORD_BITS-1:0]        sy,
    output logic                         neg_x,
    output logic                         neg_y,
    output logic [COORD_BITS-1:0]        mag_x,
    output logic [COORD_BITS-1:0]        mag_y,
    output logic [COORD_BITS-1:0]        xe_num,
    output logic [COORD_BITS-1:0]        xx_num,
    output logic [COORD_BITS-1:0]        x_den,
    output logic [COORD_BITS-1:0]        ye_num,
    output logic [COORD_BITS-1:0]        yx_num,
    output logic [COORD_BITS-1:0]        y_den
);

    localparam int W = COORD_BITS;

    logic signed [W-1:0] s_in  [2];
    logic signed [W-1:0] e_in  [2];
    logic signed [W-1:0] lo_in [2];
    logic signed [W-1:0] hi_in [2];

    // stage A
    logic signed [W-1:0] st_a_reg [2];
    logic signed [W:0]   d_a_reg  [2];
    logic signed [W:0]   en_a_reg [2];
    logic signed [W:0]   ex_a_reg [2];
    logic                val_a_reg;

    // stage B
    logic [W-1:0] st_b_reg  [2];
    logic         neg_b_reg [2];
    logic [W-1:0] mag_b_reg [2];
    logic [W-1:0] en_b_reg  [2];
    logic [W-1:0] ex_b_reg  [2];
    logic [W-1:0] den_b_reg [2];
    logic         rej_b     [2];
    lcp_pkg::lcp_ctrl_t ctrl_reg;

    assign s_in[0]  = start_x;
    assign s_in[1]  = start_y;
    assign e_in[0]  = end_x;
    assign e_in[1]  = end_y;
    assign lo_in[0] = window_left;
    assign lo_in[1] = window_bottom;
    assign hi_in[0] = window_right;
    assign hi_in[1] = window_top;

    for (genvar a = 0; a < 2; a++) begin : g_axis
        logic signed [W:0] s_ext;
        logic signed [W:0] d_c;
        logic signed [W:0] lo_ext;
        logic signed [W:0] hi_ext;
        logic signed [W:0] mag_w;
        logic              zero;
        logic              rej_e;
        logic              rej_x;
        logic [W-1:0]      en_c;
        logic [W-1:0]      ex_c;
        logic [W-1:0]      den_c;

        assign s_ext  = {s_in[a][W-1], s_in[a]};
        assign lo_ext = {lo_in[a][W-1], lo_in[a]};
        assign hi_ext = {hi_in[a][W-1], hi_in[a]};
        assign d_c    = {e_in[a][W-1], e_in[a]} - s_ext;

        always_ff @(posedge clk) begin
            if (en) begin
                st_a_reg[a] <= s_in[a];
                d_a_reg[a]  <= d_c;
                // entering and leaving edge numerators, picked by direction
                en_a_reg[a] <= d_c[W] ? (s_ext - hi_ext) : (lo_ext - s_ext);
                ex_a_reg[a] <= d_c[W] ? (s_ext - lo_ext) : (hi_ext - s_ext);
            end
        end

        assign mag_w = d_a_reg[a][W] ? -d_a_reg[a] : d_a_reg[a];
        assign zero  = (d_a_reg[a] == '0);
        assign rej_e = (en_a_reg[a] > mag_w);
        assign rej_x = ex_a_reg[a][W];
        assign en_c  = (en_a_reg[a] <= 0) ? '0 : en_a_reg[a][W-1:0];
        assign ex_c  = zero ? W'(1)
                     : ((ex_a_reg[a] >= mag_w) ? mag_w[W-1:0] : ex_a_reg[a][W-1:0]);
        assign den_c = zero ? W'(1) : mag_w[W-1:0];
        assign rej_b[a] = rej_e | rej_x;

        always_ff @(posedge clk) begin
            if (en) begin
                st_b_reg[a]  <= st_a_reg[a];
                neg_b_reg[a] <= d_a_reg[a][W];
                mag_b_reg[a] <= mag_w[W-1:0];
                en_b_reg[a]  <= en_c;
                ex_b_reg[a]  <= ex_c;
                den_b_reg[a] <= den_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            val_a_reg <= 1'b0;
            ctrl_reg  <= '0;
        end
        else if (en) begin
            val_a_reg       <= in_valid;
            ctrl_reg.valid  <= val_a_reg;
            ctrl_reg.reject <= rej_b[0] | rej_b[1];
        end
    end

    assign ctrl   = ctrl_reg;
    assign sx     = st_b_reg[0];
    assign sy     = st_b_reg[1];
    assign neg_x  = neg_b_reg[0];
    assign neg_y  = neg_b_reg[1];
    assign mag_x  = mag_b_reg[0];
    assign mag_y  = mag_b_reg[1];
    assign xe_num = en_b_reg[0];
    assign xx_num = ex_b_reg[0];
    assign x_den  = den_b_reg[0];
    assign ye_num = en_b_reg[1];
    assign yx_num = ex_b_reg[1];
    assign y_den  = den_b_reg[1];

endmodule

[src/lcp_select.sv]
module lcp_select #(
    parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF,
    parameter int SIDE_BITS  = 4 * COORD_BITS + 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  lcp_pkg::lcp_ctrl_t     ctrl_in,
    input  logic [SIDE_BITS-1:0]   side_in,
    input  logic [COORD_BITS-1:0]  xe_num,
    input  logic [COORD_BITS-1:0]  xx_num,
    input  logic [COORD_BITS-1:0]  x_den,
    input  logic [COORD_BITS-1:0]  ye_num,
    input  logic [COORD_BITS-1:0]  yx_num,
    input  logic [COORD_BITS-1:0]  y_den,
    output lcp_pkg::lcp_ctrl_t     ctrl_out,
    output logic [SIDE_BITS-1:0]   side_out,
    output logic [COORD_BITS-1:0]  en_num,
    output logic [COORD_BITS-1:0]  en_den,
    output logic [COORD_BITS-1:0]  ex_num,
    output logic [COORD_BITS-1:0]  ex_den
);

    localparam int W = COORD_BITS;

    lcp_pkg::lcp_ctrl_t ctrl_c_reg, ctrl_d_reg, ctrl_e_reg, ctrl_f_reg;
    logic [SIDE_BITS-1:0] side_c_reg, side_d_reg, side_e_reg, side_f_reg;

    // stage C: cross products between axes
    logic [2*W-1:0] pe_x_reg, pe_y_reg, px_x_reg, px_y_reg;
    logic [W-1:0]   xe_c_reg, xx_c_reg, xd_c_reg, ye_c_reg, yx_c_reg, yd_c_reg;

    // stage D: chosen limits
    logic [W-1:0] en_n_d_reg, en_d_d_reg, ex_n_d_reg, ex_d_d_reg;

    // stage E: entry vs exit cross products
    logic [2*W-1:0] pa_reg, pb_reg;
    logic [W-1:0]   en_n_e_reg, en_d_e_reg, ex_n_e_reg, ex_d_e_reg;

    // stage F
    logic [W-1:0] en_n_f_reg, en_d_f_reg, ex_n_f_reg, ex_d_f_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            pe_x_reg <= xe_num * y_den;
            pe_y_reg <= ye_num * x_den;
            px_x_reg <= xx_num * y_den;
            px_y_reg <= yx_num * x_den;
            xe_c_reg <= xe_num;
            xx_c_reg <= xx_num;
            xd_c_reg <= x_den;
            ye_c_reg <= ye_num;
            yx_c_reg <= yx_num;
            yd_c_reg <= y_den;

            // larger entry wins, smaller exit wins
            en_n_d_reg <= (pe_x_reg > pe_y_reg) ? xe_c_reg : ye_c_reg;
            en_d_d_reg <= (pe_x_reg > pe_y_reg) ? xd_c_reg : yd_c_reg;
            ex_n_d_reg <= (px_x_reg < px_y_reg) ? xx_c_reg : yx_c_reg;
            ex_d_d_reg <= (px_x_reg < px_y_reg) ? xd_c_reg : yd_c_reg;

            pa_reg     <= en_n_d_reg * ex_d_d_reg;
            pb_reg     <= ex_n_d_reg * en_d_d_reg;
            en_n_e_reg <= en_n_d_reg;
            en_d_e_reg <= en_d_d_reg;
            ex_n_e_reg <= ex_n_d_reg;
            ex_d_e_reg <= ex_d_d_reg;

            en_n_f_reg <= en_n_e_reg;
            en_d_f_reg <= en_d_e_reg;
            ex_n_f_reg <= ex_n_e_reg;
            ex_d_f_reg <= ex_d_e_reg;

            side_c_reg <= side_in;
            side_d_reg <= side_c_reg;
            side_e_reg <= side_d_reg;
            side_f_reg <= side_e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctrl_c_reg <= '0;
            ctrl_d_reg <= '0;
            ctrl_e_reg <= '0;
            ctrl_f_reg <= '0;
        end
        else if (en) begin
            ctrl_c_reg        <= ctrl_in;
            ctrl_d_reg        <= ctrl_c_reg;
            ctrl_e_reg        <= ctrl_d_reg;
            ctrl_f_reg.valid  <= ctrl_e_reg.valid;
            ctrl_f_reg.reject <= ctrl_e_reg.reject | (pa_reg > pb_reg);
        end
    end

    assign ctrl_out = ctrl_f_reg;
    assign side_out = side_f_reg;
    assign en_num   = en_n_f_reg;
    assign en_den   = en_d_f_reg;
    assign ex_num   = ex_n_f_reg;
    assign ex_den   = ex_d_f_reg;

endmodule

[src/lcp_divider.sv]
module lcp_divider #(
    parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] num,
    input  logic [COORD_BITS-1:0] den,
    input  logic [COORD_BITS-1:0] mag,
    output logic [COORD_BITS-1:0] offset
);

    // round_half_away(num * mag / den), num <= den, so the quotient fits W bits
    localparam int W = COORD_BITS;

    logic [W-1:0] rem_reg [W+1];
    logic [W-1:0] low_reg [W+1];
    logic [W-1:0] quo_reg [W+1];
    logic [W-1:0] den_reg [W+1];
    logic [W-1:0] off_reg;
    logic [2*W-1:0] prod;
    logic           inc;

    assign prod = num * mag;

    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0] <= prod[2*W-1:W];
            low_reg[0] <= prod[W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0] trial;
        logic       fits;

        assign trial = {rem_reg[k], low_reg[k][W-1]};
        assign fits  = (trial >= {1'b0, den_reg[k]});

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? W'(trial - {1'b0, den_reg[k]}) : trial[W-1:0];
                low_reg[k+1] <= {low_reg[k][W-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][W-2:0], fits};
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign inc = ({rem_reg[W], 1'b0} >= {1'b0, den_reg[W]});

    always_ff @(posedge clk) begin
        if (en) begin
            off_reg <= quo_reg[W] + W'(inc);
        end
    end

    assign offset = off_reg;

endmodule

[src/line_clip_parametric_unit.sv]
// Channel  | Handshake              | Beat
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | start_x, start_y, end_x, end_y
// out      | out_valid / out_stall  | visible, clipped_start_x/y, clipped_end_x/y
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat per cycle in and out while the output is not stalled. The rounding dividers
// resolve one quotient bit per stage.
// Reset is asynchronous; it clears all valid bits and loads the default window.
// When the output beat is stalled the whole pipeline holds in place; in_stall
// follows out_stall only while a beat sits in the output register.
// cfg_ready is always high.
module line_clip_parametric_unit #(
    parameter int COORD_BITS = lcp_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                visible,
    output logic signed [COORD_BITS-1:0]        clipped_start_x,
    output logic signed [COORD_BITS-1:0]        clipped_start_y,
    output logic signed [COORD_BITS-1:0]        clipped_end_x,
    output logic signed [COORD_BITS-1:0]        clipped_end_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data
);

    localparam int W        = COORD_BITS;
    localparam int SIDE_W   = 4 * W + 2;
    localparam int DIV_LAT  = W + 2;
    localparam int TAIL_W   = 2 * W + 2;

    // window registers
    logic signed [W-1:0] win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    // global advance: everything moves unless a finished beat is held
    logic en;

    // setup -> select
    lcp_pkg::lcp_ctrl_t su_ctrl;
    logic [W-1:0] su_sx, su_sy, su_mag_x, su_mag_y;
    logic         su_neg_x, su_neg_y;
    logic [W-1:0] su_xe, su_xx, su_xd, su_ye, su_yx, su_yd;

    // select -> dividers
    lcp_pkg::lcp_ctrl_t sel_ctrl;
    logic [SIDE_W-1:0]  sel_side;
    logic [W-1:0]       en_num, en_den, ex_num, ex_den;
    logic [W-1:0]       sel_mag_x, sel_mag_y;

    // side data riding next to the dividers: sx, sy, neg_x, neg_y
    lcp_pkg::lcp_ctrl_t tail_ctrl_reg [DIV_LAT];
    logic [TAIL_W-1:0]  tail_reg      [DIV_LAT];

    logic [W-1:0] off_sx, off_sy, off_ex, off_ey;
    logic [W-1:0] t_sx, t_sy;
    logic         t_nx, t_ny;

    logic         out_valid_reg, visible_reg;
    logic [W-1:0] cs_x_reg, cs_y_reg, ce_x_reg, ce_y_reg;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_left_reg   <= '0;
            win_bottom_reg <= '0;
            win_right_reg  <= {1'b0, {(W-1){1'b1}}};
            win_top_reg    <= {1'b0, {(W-1){1'b1}}};
        end
        else if (cfg_valid) begin
            unique case (cfg_index)
                lcp_pkg::REG_LEFT:   win_left_reg   <= cfg_data;
                lcp_pkg::REG_BOTTOM: win_bottom_reg <= cfg_data;
                lcp_pkg::REG_RIGHT:  win_right_reg  <= cfg_data;
                lcp_pkg::REG_TOP:    win_top_reg    <= cfg_data;
                default: ; // unused index, write dropped
            endcase
        end
    end

    // edge classification and clamping, two stages
    lcp_setup #(.COORD_BITS(W)) u_setup (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .window_left   (win_left_reg),
        .window_bottom (win_bottom_reg),
        .window_right  (win_right_reg),
        .window_top    (win_top_reg),
        .ctrl          (su_ctrl),
        .sx            (su_sx),
        .sy            (su_sy),
        .neg_x         (su_neg_x),
        .neg_y         (su_neg_y),
        .mag_x         (su_mag_x),
        .mag_y         (su_mag_y),
        .xe_num        (su_xe),
        .xx_num        (su_xx),
        .x_den         (su_xd),
        .ye_num        (su_ye),
        .yx_num        (su_yx),
        .y_den         (su_yd)
    );

    // pick entry/exit fractions and test entry > exit, four stages
    lcp_select #(.COORD_BITS(W), .SIDE_BITS(SIDE_W)) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctrl_in  (su_ctrl),
        .side_in  ({su_sx, su_sy, su_neg_x, su_neg_y, su_mag_x, su_mag_y}),
        .xe_num   (su_xe),
        .xx_num   (su_xx),
        .x_den    (su_xd),
        .ye_num   (su_ye),
        .yx_num   (su_yx),
        .y_den    (su_yd),
        .ctrl_out (sel_ctrl),
        .side_out (sel_side),
        .en_num   (en_num),
        .en_den   (en_den),
        .ex_num   (ex_num),
        .ex_den   (ex_den)
    );

    assign sel_mag_x = sel_side[2*W-1:W];
    assign sel_mag_y = sel_side[W-1:0];

    // one rounding divider per output coordinate
    lcp_divider #(.COORD_BITS(W)) u_div_sx (
        .clk(clk), .en(en), .num(en_num), .den(en_den), .mag(sel_mag_x), .offset(off_sx)
    );
    lcp_divider #(.COORD_BITS(W)) u_div_sy (
        .clk(clk), .en(en), .num(en_num), .den(en_den), .mag(sel_mag_y), .offset(off_sy)
    );
    lcp_divider #(.COORD_BITS(W)) u_div_ex (
        .clk(clk), .en(en), .num(ex_num), .den(ex_den), .mag(sel_mag_x), .offset(off_ex)
    );
    lcp_divider #(.COORD_BITS(W)) u_div_ey (
        .clk(clk), .en(en), .num(ex_num), .den(ex_den), .mag(sel_mag_y), .offset(off_ey)
    );

    // delay line matching divider latency
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                tail_ctrl_reg[i] <= '0;
            end
        end
        else if (en) begin
            tail_ctrl_reg[0] <= sel_ctrl;
            for (int i = 1; i < DIV_LAT; i++) begin
                tail_ctrl_reg[i] <= tail_ctrl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            tail_reg[0] <= sel_side[SIDE_W-1:2*W];
            for (int i = 1; i < DIV_LAT; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    assign t_sx = tail_reg[DIV_LAT-1][2*W+1:W+2];
    assign t_sy = tail_reg[DIV_LAT-1][W+1:2];
    assign t_nx = tail_reg[DIV_LAT-1][1];
    assign t_ny = tail_reg[DIV_LAT-1][0];

    // output register: apply offsets along the direction, zero on reject
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= tail_ctrl_reg[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            if (tail_ctrl_reg[DIV_LAT-1].reject) begin
                visible_reg <= 1'b0;
                cs_x_reg    <= '0;
                cs_y_reg    <= '0;
                ce_x_reg    <= '0;
                ce_y_reg    <= '0;
            end
            else begin
                visible_reg <= 1'b1;
                cs_x_reg    <= t_nx ? (t_sx - off_sx) : (t_sx + off_sx);
                cs_y_reg    <= t_ny ? (t_sy - off_sy) : (t_sy + off_sy);
                ce_x_reg    <= t_nx ? (t_sx - off_ex) : (t_sx + off_ex);
                ce_y_reg    <= t_ny ? (t_sy - off_ey) : (t_sy + off_ey);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign visible         = visible_reg;
    assign clipped_start_x = cs_x_reg;
    assign clipped_start_y = cs_y_reg;
    assign clipped_end_x   = ce_x_reg;
    assign clipped_end_y   = ce_y_reg;

endmodule
